### sv/pdd_pkg.sv
`default_nettype none
package pdd_pkg;

  localparam int unsigned DutyW   = 16;
  localparam int unsigned CountW  = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [DutyW-1:0]  PeriodRst    = 16'd160;
  localparam logic [DutyW-1:0]  StepRst      = 16'd8;
  localparam logic [CountW-1:0] ThresholdRst = 32'd6500000;
  localparam logic [DutyW-1:0]  DutyRst      = 16'd80;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PERIOD    = 2'd0,
    CFG_STEP      = 2'd1,
    CFG_THRESHOLD = 2'd2,
    CFG_NONE      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [DutyW-1:0]  period;
    logic [DutyW-1:0]  step;
    logic [CountW-1:0] threshold;
  } cfg_t;

  // press handling result for the current beat
  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic             timing;
  } press_next_t;

  typedef struct packed {
    logic             led_level;
    logic [DutyW-1:0] duty_now;
    logic             press_timing;
  } result_t;

endpackage
`default_nettype wire

### sv/pdd_in_if.sv
`default_nettype none
interface pdd_in_if;
  logic valid;
  logic ready;
  logic button_edge;

  modport source (output valid, output button_edge, input ready);
  modport sink (input valid, input button_edge, output ready);
endinterface
`default_nettype wire

### sv/pdd_out_if.sv
`default_nettype none
interface pdd_out_if;
  logic        valid;
  logic        ready;
  logic        led_level;
  logic [15:0] duty_now;
  logic        press_timing;

  modport source (output valid, output led_level, output duty_now, output press_timing,
                  input ready);
  modport sink (input valid, input led_level, input duty_now, input press_timing,
                output ready);
endinterface
`default_nettype wire

### sv/pdd_press.sv
`default_nettype none
module pdd_press
  import pdd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        fire_i,
  input  wire logic        edge_i,
  input  wire cfg_t        cfg_i,
  output press_next_t      next_o
);

  logic [CountW-1:0] count_q, count_d;
  logic              active_q, active_d;
  logic [DutyW-1:0]  duty_q, duty_d;
  logic [DutyW:0]    sum;
  logic [DutyW-1:0]  raised, lowered;

  assign sum     = {1'b0, duty_q} + {1'b0, cfg_i.step};
  assign raised  = (sum > {1'b0, cfg_i.period}) ? cfg_i.period : sum[DutyW-1:0];
  assign lowered = (duty_q > cfg_i.step) ? (duty_q - cfg_i.step) : '0;

  always_comb begin
    count_d  = count_q;
    active_d = active_q;
    duty_d   = duty_q;
    if (edge_i) begin
      count_d  = '0;
      active_d = !active_q;
      if (active_q) begin
        duty_d = (count_q < cfg_i.threshold) ? raised : lowered;
      end
    end else if (active_q && (count_q != {CountW{1'b1}})) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      active_q <= 1'b0;
      duty_q   <= DutyRst;
    end else if (fire_i) begin
      count_q  <= count_d;
      active_q <= active_d;
      duty_q   <= duty_d;
    end
  end

  assign next_o.duty   = duty_d;
  assign next_o.timing = active_d;

endmodule
`default_nettype wire

### sv/pdd_pwm.sv
`default_nettype none
module pdd_pwm
  import pdd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire logic [DutyW-1:0] period_i,
  input  wire logic [DutyW-1:0] duty_i,
  output logic                  led_o
);

  logic [DutyW-1:0] phase_q, phase_d;
  logic [DutyW:0]   phase_inc;

  assign led_o     = (phase_q < duty_i);
  assign phase_inc = {1'b0, phase_q} + 1'b1;
  assign phase_d   = (phase_inc >= {1'b0, period_i}) ? '0 : phase_inc[DutyW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
    end
  end

endmodule
`default_nettype wire

### sv/pdd_out_skid.sv
`default_nettype none
module pdd_out_skid
  import pdd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire result_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output result_t      out_data_o
);

  logic    main_valid_q, skid_valid_q;
  result_t main_q, skid_q;
  logic    in_fire, out_fire;

  assign in_ready_o  = !skid_valid_q;
  assign in_fire     = in_valid_i && !skid_valid_q;
  assign out_fire    = main_valid_q && out_ready_i;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!main_valid_q || (out_fire && !skid_valid_q)) begin
        main_valid_q <= in_fire;
      end else if (out_fire) begin
        skid_valid_q <= in_fire;
      end else if (in_fire) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_valid_q || (out_fire && !skid_valid_q)) begin
      main_q <= in_data_i;
    end else if (out_fire) begin
      main_q <= skid_q;
      skid_q <= in_data_i;
    end else if (in_fire) begin
      skid_q <= in_data_i;
    end
  end

endmodule
`default_nettype wire

### sv/press_duration_pwm_dimmer.sv
// One-button PWM dimmer. Each input beat on in_i is one tick; button_edge
// marks a button edge in that tick. Edges alternate between starting and
// ending a press; a press shorter than threshold ticks raises the duty by
// step (clamped at period), one of threshold ticks or more lowers it
// (clamped at 0). Every input beat yields one output beat on out_o with the
// LED level, the duty after this tick and whether a press is being timed.
// Configuration: cfg_we_i, cfg_idx_i (0 period, 1 step, 2 threshold) and
// cfg_wdata_i; the user must write them only while no beat is in flight;
// the block does not enforce it. Results are registered in the output stage.
// Throughput: one beat per cycle while out_o does not stall; press, duty and
// phase update in one pass between the input handshake and the result register.
// A two-entry output stage (result register plus skid) keeps in_i.ready
// registered: while out_o stalls, one more beat is taken, then ready drops.
// Reset: period 160, step 8, threshold 6500000, duty 80, phase 0, no press
// timed, output stage empty.
`default_nettype none
module press_duration_pwm_dimmer
  import pdd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  pdd_in_if.sink                   in_i,
  pdd_out_if.source                out_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t        cfg_q;
  logic        in_ready, in_fire, led;
  press_next_t press_next;
  result_t     result, out_data;
  cfg_idx_e    cfg_idx;

  assign cfg_idx = cfg_idx_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period    <= PeriodRst;
      cfg_q.step      <= StepRst;
      cfg_q.threshold <= ThresholdRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx)
        CFG_PERIOD:    cfg_q.period    <= cfg_wdata_i[DutyW-1:0];
        CFG_STEP:      cfg_q.step      <= cfg_wdata_i[DutyW-1:0];
        CFG_THRESHOLD: cfg_q.threshold <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = in_ready;
  assign in_fire    = in_i.valid && in_ready;

  pdd_press u_press (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .edge_i (in_i.button_edge),
    .cfg_i  (cfg_q),
    .next_o (press_next)
  );

  pdd_pwm u_pwm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (in_fire),
    .period_i (cfg_q.period),
    .duty_i   (press_next.duty),
    .led_o    (led)
  );

  assign result.led_level    = led;
  assign result.duty_now     = press_next.duty;
  assign result.press_timing = press_next.timing;

  pdd_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .in_data_i   (result),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data)
  );

  assign out_o.led_level    = out_data.led_level;
  assign out_o.duty_now     = out_data.duty_now;
  assign out_o.press_timing = out_data.press_timing;

endmodule
`default_nettype wire

### tb/sv/pdd_dimmer_checker.sv
`timescale 1ns / 100ps
module pdd_dimmer_checker
  import pdd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  pdd_in_if                   in_mon,
  pdd_out_if                  out_mon,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int                  errors_o,
  output int                  pending_o
);

  cfg_t              cfg;
  logic [DutyW-1:0]  duty;
  logic [DutyW-1:0]  phase;
  logic [CountW-1:0] press_cnt;
  logic              timing;
  result_t           tick_results_q[$];
  int                errors = 0;

  task automatic report_mismatch(input string what);
    if (errors < 40) begin
      $display("[%0t] MISMATCH: %s", $time, what);
    end
    errors++;
  endtask

  // one tick: press handling, then LED from phase and new duty, then phase advance
  task automatic dimmer_tick(input logic btn, output result_t r);
    logic [DutyW:0] sum;
    if (btn) begin
      if (timing) begin
        if (press_cnt < cfg.threshold) begin
          sum  = {1'b0, duty} + {1'b0, cfg.step};
          duty = (sum > {1'b0, cfg.period}) ? cfg.period : sum[DutyW-1:0];
        end else begin
          duty = (duty > cfg.step) ? duty - cfg.step : '0;
        end
        timing = 1'b0;
      end else begin
        timing = 1'b1;
      end
      press_cnt = '0;
    end else if (timing && press_cnt != '1) begin
      press_cnt++;
    end
    r.led_level    = (phase < duty);
    r.duty_now     = duty;
    r.press_timing = timing;
    sum   = {1'b0, phase} + 1'b1;
    phase = (sum >= {1'b0, cfg.period}) ? '0 : sum[DutyW-1:0];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t got;
    result_t want;
    result_t fresh;
    if (!rst_ni) begin
      cfg.period    = PeriodRst;
      cfg.step      = StepRst;
      cfg.threshold = ThresholdRst;
      duty          = DutyRst;
      phase         = '0;
      press_cnt     = '0;
      timing        = 1'b0;
      tick_results_q.delete();
      pending_o <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.led_level    = out_mon.led_level;
        got.duty_now     = out_mon.duty_now;
        got.press_timing = out_mon.press_timing;
        if (tick_results_q.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected (duty %0d)",
                                    got.duty_now));
        end else begin
          want = tick_results_q.pop_front();
          if (got.led_level !== want.led_level)
            report_mismatch($sformatf("led_level got %b want %b",
                                      got.led_level, want.led_level));
          if (got.duty_now !== want.duty_now)
            report_mismatch($sformatf("duty_now got %0d want %0d",
                                      got.duty_now, want.duty_now));
          if (got.press_timing !== want.press_timing)
            report_mismatch($sformatf("press_timing got %b want %b",
                                      got.press_timing, want.press_timing));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        dimmer_tick(in_mon.button_edge, fresh);
        tick_results_q.push_back(fresh);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PERIOD:    cfg.period = cfg_wdata_i[DutyW-1:0];
          CFG_STEP:      cfg.step = cfg_wdata_i[DutyW-1:0];
          CFG_THRESHOLD: cfg.threshold = cfg_wdata_i[CountW-1:0];
          default: ;
        endcase
      end
      pending_o <= tick_results_q.size();
    end
    errors_o <= errors;
  end

endmodule

### tb/sv/tb_press_duration_pwm_dimmer.sv
`timescale 1ns / 100ps
module tb_press_duration_pwm_dimmer
  import pdd_pkg::*;
;

  localparam int CycleLimit  = 200000;
  localparam int RandomItems = 110;
  // directed ticks after the small setting: clamp at period, lower, clamp at 0, raise, clamp at period again
  localparam logic [17:0] DirectedTicks = 18'b00_11_10001_1001_101_11;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = CFG_NONE;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  int errors;
  int pending;
  int snd_idle = 0;
  int rcv_idle = 0;
  int cycles = 0;
  int ticks_sent = 0;
  int edges_sent = 0;
  int settings_used = 0;
  logic [CountW-1:0] cur_thr = ThresholdRst;

  pdd_in_if  in_ch ();
  pdd_out_if out_ch ();

  press_duration_pwm_dimmer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  pdd_dimmer_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
    out_ch.ready <= ($urandom_range(99) >= rcv_idle);
  end

  task automatic send_tick(input logic b);
    while ($urandom_range(99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.button_edge <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    ticks_sent++;
    edges_sent += int'(b);
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [DutyW-1:0] p, input logic [DutyW-1:0] s,
                               input logic [CountW-1:0] t);
    wait_drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_NONE;
    cfg_wdata_i <= $urandom;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_PERIOD;
    cfg_wdata_i <= {16'($urandom), p};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_STEP;
    cfg_wdata_i <= {16'($urandom), s};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_THRESHOLD;
    cfg_wdata_i <= t;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_thr = t;
    settings_used++;
  endtask

  // mostly press/release pairs timed around the threshold (around 20 ticks when it is above 40), some loose edges
  task automatic run_random(input int n);
    int   sent;
    int   base;
    int   dur;
    int   gap;
    int   reps;
    logic b;
    sent = 0;
    while (sent < n) begin
      base = (cur_thr > 40) ? 20 : int'(cur_thr);
      if ($urandom_range(99) < 80) begin
        if ($urandom_range(1)) dur = base - 1 + $urandom_range(2);
        else dur = $urandom_range(2 * base);
        gap = $urandom_range(4);
        send_tick(1'b1);
        repeat (dur) send_tick(1'b0);
        send_tick(1'b1);
        repeat (gap) send_tick(1'b0);
        sent += dur + gap + 2;
      end else begin
        b    = 1'($urandom_range(1));
        reps = $urandom_range(1, 6);
        repeat (reps) send_tick(b);
        sent += reps;
      end
    end
  endtask

  initial begin : stimulus
    in_ch.valid       = 1'b0;
    in_ch.button_edge = 1'b0;
    out_ch.ready      = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults: duty starts at half the period, one short press
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);

    // period far below duty, even threshold
    apply_setting(16'd4, 16'd3, 32'd2);
    for (int i = 17; i >= 0; i--) send_tick(DirectedTicks[i]);

    for (int k = 0; k < 9; k++) begin
      case (k / 3)
        0: begin snd_idle = 19; rcv_idle = 59; end
        1: begin snd_idle = 59; rcv_idle = 19; end
        default: begin snd_idle = 0; rcv_idle = 0; end
      endcase
      case (k)
        0: apply_setting(16'd2, 16'd0, 32'd1);
        1: apply_setting(16'd24, 16'd5, 32'd6);
        2: apply_setting(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        3: apply_setting(16'hFFFF, 16'hFFFF, 32'd3);
        4: apply_setting(16'($urandom_range(2, 64)), 16'($urandom_range(0, 16)),
                         $urandom_range(1, 20));
        5: apply_setting(PeriodRst, StepRst, ThresholdRst);
        6: apply_setting(16'd3, 16'hFFFF, 32'd2);
        7: apply_setting(16'($urandom_range(2, 200)), 16'($urandom_range(0, 50)),
                         $urandom_range(1, 40));
        default: apply_setting(16'($urandom_range(2, 65535)), 16'($urandom_range(0, 65535)),
                               $urandom_range(1, 40));
      endcase
      run_random(RandomItems);
    end

    wait_drain();
    $display("Covered %0d ticks with %0d button edges over %0d register settings,",
             ticks_sent, edges_sent, settings_used);
    $display("with sender-heavy, receiver-heavy and stall-free handshake mixes.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
sv/pdd_pkg.sv
sv/pdd_in_if.sv
sv/pdd_out_if.sv
sv/pdd_press.sv
sv/pdd_pwm.sv
sv/pdd_out_skid.sv
sv/press_duration_pwm_dimmer.sv
tb/sv/pdd_dimmer_checker.sv
tb/sv/tb_press_duration_pwm_dimmer.sv
